/* src/lrc_pkg.sv */
package lrc_pkg;

  // Stream widths
  localparam int IN_W  = 80;
  localparam int OUT_W = 104;

  // Frame and laser geometry
  localparam logic [11:0] MAX_COLUMNS = 12'd2048;
  localparam int          LASER_COUNT = 16;
  localparam int          EL_BASE     = 34500;  // lowest laser, -15 deg plus a full turn
  localparam int          EL_STEP     = 200;    // two degrees per laser

  // Angles in hundredths of a degree
  localparam logic [15:0] FULL_TURN = 16'd36000;
  localparam logic [13:0] QUARTER   = 14'd9000;
  localparam logic [13:0] EIGHTH    = 14'd4500;

  // Quadrant split: a / 9000 by reciprocal
  localparam int          Q_SHIFT = 30;
  localparam logic [16:0] Q_MUL   = 17'(((64'd1 << Q_SHIFT) + 64'd8999) / 64'd9000);

  // Radians in Q30: b*PI_Q30/18000 = b*PI_K + (b*PI_R + 9000)/18000
  localparam logic [17:0] PI_K      = 18'd187403;
  localparam logic [12:0] PI_R      = 13'd5426;
  localparam logic [24:0] RAD_HALF  = 25'd9000;
  localparam int          R_SHIFT   = 40;
  localparam logic [25:0] R_MUL     = 26'(((64'd1 << R_SHIFT) + 64'd17999) / 64'd18000);

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Taylor divisors, innermost term first
  localparam int unsigned SIN_DIV [6] = '{156, 110, 72, 42, 20, 6};
  localparam int unsigned COS_DIV [6] = '{132, 90, 56, 30, 12, 2};
  localparam int          TERMS       = 6;

  // Divider: one quotient bit per cell
  localparam int QUO_W = 16;
  localparam int NUM_W = 27;
  localparam int DEN_W = 11;

  typedef enum logic [1:0] {
    REG_MIN_RANGE = 2'd0,
    REG_Z_UPPER   = 2'd1,
    REG_Z_LOWER   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [DEN_W-1:0] den;
  } div_t;

  typedef struct packed {
    logic [29:0] x2;
    logic [30:0] t;
  } horner_t;

  typedef struct packed {
    logic [30:0] sn_mag;
    logic        sn_neg;
    logic [30:0] cs_mag;
    logic        cs_neg;
  } trig_res_t;

endpackage

/* src/lidar_return_to_cartesian_top.sv */
// Pipeline: front register, 16-cell divider, azimuth stage, 19-stage sine/cosine
// pipeline, scaling stage, output register.
// Throughput: one item per cycle unless the skid is full; every stage advances
// together; a two-entry output buffer absorbs one item while downstream stalls.
// Reset: rst_n synchronous active low clears valids and loads the limits
// to min_range 256, z_upper 2560, z_lower -512.
module lidar_return_to_cartesian_top (
  input  logic                      clk,
  input  logic                      rst_n,
  // distance[15:0] laser[19:16] column[30:20] column_count[42:31]
  // start_azimuth[58:43] end_azimuth[74:59], zero fill above
  input  logic [lrc_pkg::IN_W-1:0]  in_tdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // pos_x[16:0] pos_y[33:17] pos_z[50:34] point_azimuth[66:51]
  // range_out[82:67] column_out[93:83] laser_out[97:94], zero fill above
  output logic [lrc_pkg::OUT_W-1:0] out_tdata,
  // excluded[0]
  output logic                      out_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [16:0]               cfg_data
);
  import lrc_pkg::*;

  localparam int TD = 20;

  typedef struct packed {
    logic [15:0] rng;
    logic [3:0]  laser;
    logic [10:0] col;
    logic [15:0] start;
    logic        neg;
    logic        single;
  } side1_t;

  typedef struct packed {
    logic [15:0] rng;
    logic [3:0]  laser;
    logic [10:0] col;
    logic [15:0] az;
  } side2_t;

  typedef struct packed {
    logic [16:0] x;
    logic [16:0] y;
    logic [16:0] z;
    logic [15:0] az;
    logic [15:0] range;
    logic        excl;
    logic [10:0] col;
    logic [3:0]  laser;
  } out_t;

  logic        en;
  logic [15:0] min_range_r;
  logic [16:0] z_upper_r, z_lower_r;
  out_t        out_r, skid_r;
  logic        out_v_r, skid_v_r;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_r <= 16'd256;
      z_upper_r   <= 17'd2560;
      z_lower_r   <= -17'sd512;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_RANGE: min_range_r <= cfg_data[15:0];
        REG_Z_UPPER:   z_upper_r   <= cfg_data;
        REG_Z_LOWER:   z_lower_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front stage: clamp count and column, form |end-start| * column
  logic [15:0] in_dist, in_start, in_end;
  logic [3:0]  in_laser;
  logic [10:0] in_col, col_sat, den;
  logic [11:0] cnt_sat;
  logic        single;
  logic [16:0] diff;
  logic [15:0] mag;
  side1_t      s1_nxt;
  div_t        d0_nxt;

  always_comb begin
    in_dist  = in_tdata[15:0];
    in_laser = in_tdata[19:16];
    in_col   = in_tdata[30:20];
    in_start = in_tdata[58:43];
    in_end   = in_tdata[74:59];
    cnt_sat  = (in_tdata[42:31] > MAX_COLUMNS) ? MAX_COLUMNS : in_tdata[42:31];
    single   = cnt_sat <= 12'd1;
    den      = single ? '0 : 11'(cnt_sat - 12'd1);
    col_sat  = (in_col > den) ? den : in_col;
    diff     = {1'b0, in_end} - {1'b0, in_start};
    mag      = diff[16] ? 16'(-diff) : diff[15:0];
    s1_nxt   = '{rng: in_dist, laser: in_laser, col: in_col, start: in_start,
                 neg: diff[16], single: single};
    d0_nxt.rem = NUM_W'(mag) * NUM_W'(col_sat);
    d0_nxt.quo = '0;
    d0_nxt.den = den;
  end

  assign en        = !skid_v_r;
  assign in_tready = en;

  div_t        ds [QUO_W+1];
  div_t        ds_r0;
  side1_t      sd1_r [QUO_W+1];
  logic        vd1_r [QUO_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      ds_r0     <= d0_nxt;
      sd1_r[0]  <= s1_nxt;
      for (int i = 1; i <= QUO_W; i++) sd1_r[i] <= sd1_r[i-1];
    end
  end

  assign ds[0] = ds_r0;

  // Restoring divider, most significant quotient bit first
  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    lrc_div_cell #(.BIT(QUO_W - 1 - g)) u_div (
      .clk(clk), .en(en), .cell_i(ds[g]), .cell_o(ds[g+1])
    );
  end

  // Interpolated azimuth and elevation angle
  logic [16:0] az17;
  logic [15:0] az_nxt, az_r, el_r;
  side1_t      sp;
  side2_t      sd2_r [TD];

  always_comb begin
    sp     = sd1_r[QUO_W];
    az17   = sp.neg ? ({1'b0, sp.start} - {1'b0, ds[QUO_W].quo})
                    : ({1'b0, sp.start} + {1'b0, ds[QUO_W].quo});
    if (sp.single) az17 = {1'b0, sp.start};
    az_nxt = (az17[15:0] >= FULL_TURN) ? (az17[15:0] - FULL_TURN) : az17[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      az_r     <= az_nxt;
      el_r     <= 16'(EL_BASE + EL_STEP * int'(sp.laser));
      sd2_r[0] <= '{rng: sp.rng, laser: sp.laser, col: sp.col, az: az_nxt};
      for (int i = 1; i < TD; i++) sd2_r[i] <= sd2_r[i-1];
    end
  end

  trig_res_t az_t, el_t;

  lrc_trig u_trig_az (.clk(clk), .en(en), .angle_i(az_r), .res_o(az_t));
  lrc_trig u_trig_el (.clk(clk), .en(en), .angle_i(el_r), .res_o(el_t));

  // Range times elevation terms
  logic [47:0] rc_prod, zm_prod;
  logic [30:0] rc_r;
  logic [16:0] z_r, zm;
  trig_res_t   azt_r;
  side2_t      s2_r;

  always_comb begin
    rc_prod = 48'(48'(sd2_r[TD-1].rng) * 48'(el_t.cs_mag)) + (48'(1) << 15);
    zm_prod = 48'(48'(sd2_r[TD-1].rng) * 48'(el_t.sn_mag)) + (48'(1) << 29);
    zm      = zm_prod[46:30];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rc_r  <= rc_prod[46:16];
      z_r   <= el_t.sn_neg ? 17'(-zm) : zm;
      azt_r <= az_t;
      s2_r  <= sd2_r[TD-1];
    end
  end

  // Valid line through every stage
  logic vt_r [TD];
  logic vf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
      for (int i = 0; i <= QUO_W; i++) vd1_r[i] <= 1'b0;
      for (int i = 0; i < TD; i++) vt_r[i] <= 1'b0;
    end else if (en) begin
      vd1_r[0] <= in_tvalid;
      for (int i = 1; i <= QUO_W; i++) vd1_r[i] <= vd1_r[i-1];
      vt_r[0]  <= vd1_r[QUO_W];
      for (int i = 1; i < TD; i++) vt_r[i] <= vt_r[i-1];
      vf_r     <= vt_r[TD-1];
    end
  end

  // Final scaling to Q8.8 and the exclusion test
  logic [62:0] xp, yp;
  logic [16:0] xm, ym;
  out_t        res_nxt;

  always_comb begin
    xp = 63'(63'(rc_r) * 63'(azt_r.sn_mag)) + (63'(1) << 43);
    yp = 63'(63'(rc_r) * 63'(azt_r.cs_mag)) + (63'(1) << 43);
    xm = xp[60:44];
    ym = yp[60:44];
    res_nxt.x     = azt_r.sn_neg ? 17'(-xm) : xm;
    res_nxt.y     = azt_r.cs_neg ? 17'(-ym) : ym;
    res_nxt.z     = z_r;
    res_nxt.az    = s2_r.az;
    res_nxt.range = s2_r.rng;
    res_nxt.excl  = (s2_r.rng <= min_range_r) ||
                    !(($signed(z_r) < $signed(z_upper_r)) &&
                      ($signed(z_r) > $signed(z_lower_r)));
    res_nxt.col   = s2_r.col;
    res_nxt.laser = s2_r.laser;
  end

  // Output register with one skid entry
  logic push;

  assign push = en && vf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      out_r <= skid_v_r ? skid_r : res_nxt;
    end else if (push) begin
      skid_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.excl;
  assign out_tdata  = {6'b0, out_r.laser, out_r.col, out_r.range, out_r.az,
                       out_r.z, out_r.y, out_r.x};

endmodule

/* src/lrc_div_cell.sv */
module lrc_div_cell #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  lrc_pkg::div_t cell_i,
  output lrc_pkg::div_t cell_o
);
  import lrc_pkg::*;

  div_t             cell_r;
  div_t             cell_nxt;
  logic [NUM_W-1:0] sub;

  // Try one shifted divisor, keep the bit if it fits
  always_comb begin
    cell_nxt = cell_i;
    sub      = NUM_W'(cell_i.den) << BIT;
    if (cell_i.rem >= sub) begin
      cell_nxt.rem = cell_i.rem - sub;
      cell_nxt.quo = cell_i.quo | (QUO_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

/* src/lrc_horner_cell.sv */
module lrc_horner_cell #(
  parameter int unsigned DIV = 2
) (
  input  logic             clk,
  input  logic             en,
  input  lrc_pkg::horner_t cell_i,
  output lrc_pkg::horner_t cell_o
);
  import lrc_pkg::*;

  localparam int unsigned K   = $clog2(DIV + 1);
  localparam int unsigned SH  = 30 + K;
  localparam logic [31:0] MUL = 32'(((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV));

  logic [29:0] p_r, p_nxt, x2a_r;
  logic [30:0] t_r, t_nxt;
  logic [29:0] x2b_r;
  logic [60:0] prod_a;
  logic [61:0] prod_b;

  // First half: x2 * t in Q30
  always_comb begin
    prod_a = 61'(cell_i.x2) * 61'(cell_i.t);
    p_nxt  = prod_a[59:30];
  end

  // Second half: divide by the term constant, subtract from one
  always_comb begin
    prod_b = 62'(p_r) * 62'(MUL);
    t_nxt  = ONE_Q30 - 31'(prod_b >> SH);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= p_nxt;
      x2a_r <= cell_i.x2;
      t_r   <= t_nxt;
      x2b_r <= x2a_r;
    end
  end

  assign cell_o.x2 = x2b_r;
  assign cell_o.t  = t_r;

endmodule

/* src/lrc_trig.sv */
module lrc_trig (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        angle_i,
  output lrc_pkg::trig_res_t res_o
);
  import lrc_pkg::*;

  typedef struct packed {
    logic [1:0] quad;
    logic       swap;
  } oct_t;

  localparam int XD = 2 * TERMS + 1;
  localparam int QD = 2 * TERMS + 5;

  logic [15:0] a1_r;
  logic [2:0]  q1_r;
  logic [32:0] qprod;
  logic [12:0] b2_r, b_nxt;
  logic [13:0] rem14;
  oct_t        oct_nxt;
  oct_t        qd_r [QD];
  logic [30:0] kb_r;
  logic [24:0] v_r;
  logic [29:0] x_r;
  logic [50:0] rprod;
  logic [60:0] xsq;
  logic [29:0] x2_r;
  logic [29:0] xd_r [XD];
  horner_t     hs [TERMS+1];
  horner_t     hc [TERMS+1];
  logic [30:0] s_r, c_r;
  logic [60:0] sprod;
  logic [30:0] bs, bc;
  trig_res_t   res_r, res_nxt;

  // Reduce to octant
  always_comb begin
    qprod   = 33'(angle_i) * 33'(Q_MUL);
    rem14   = 14'(a1_r - 16'(q1_r) * 16'(QUARTER));
    oct_nxt.quad = q1_r[1:0];
    oct_nxt.swap = rem14 > EIGHTH;
    b_nxt   = oct_nxt.swap ? 13'(QUARTER - rem14) : rem14[12:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r     <= angle_i;
      q1_r     <= qprod[Q_SHIFT+2:Q_SHIFT];
      b2_r     <= b_nxt;
      qd_r[0]  <= oct_nxt;
      for (int i = 1; i < QD; i++) qd_r[i] <= qd_r[i-1];
      kb_r     <= 31'(b2_r) * 31'(PI_K);
      v_r      <= 25'(b2_r) * 25'(PI_R) + RAD_HALF;
      x_r      <= 30'(kb_r) + 30'(rprod >> R_SHIFT);
      x2_r     <= xsq[59:30];
      xd_r[0]  <= x_r;
      for (int i = 1; i < XD; i++) xd_r[i] <= xd_r[i-1];
      s_r      <= sprod[60:30];
      c_r      <= hc[TERMS].t;
      res_r    <= res_nxt;
    end
  end

  // Angle in radians, then its square
  always_comb begin
    rprod = 51'(v_r) * 51'(R_MUL);
    xsq   = 61'(61'(x_r) * 61'(x_r)) + (61'(1) << 29);
  end

  // Horner chains for sin/x and cos
  assign hs[0] = '{x2: x2_r, t: ONE_Q30};
  assign hc[0] = '{x2: x2_r, t: ONE_Q30};

  for (genvar g = 0; g < TERMS; g++) begin : g_term
    lrc_horner_cell #(.DIV(SIN_DIV[g])) u_sin (
      .clk(clk), .en(en), .cell_i(hs[g]), .cell_o(hs[g+1])
    );
    lrc_horner_cell #(.DIV(COS_DIV[g])) u_cos (
      .clk(clk), .en(en), .cell_i(hc[g]), .cell_o(hc[g+1])
    );
  end

  assign sprod = 61'(xd_r[XD-1]) * 61'(hs[TERMS].t);

  // Undo octant swap and apply quadrant signs
  always_comb begin
    bs = qd_r[QD-1].swap ? c_r : s_r;
    bc = qd_r[QD-1].swap ? s_r : c_r;
    res_nxt = '0;
    case (qd_r[QD-1].quad)
      2'd0: res_nxt = '{sn_mag: bs, sn_neg: 1'b0, cs_mag: bc, cs_neg: 1'b0};
      2'd1: res_nxt = '{sn_mag: bc, sn_neg: 1'b0, cs_mag: bs, cs_neg: 1'b1};
      2'd2: res_nxt = '{sn_mag: bs, sn_neg: 1'b1, cs_mag: bc, cs_neg: 1'b1};
      default: res_nxt = '{sn_mag: bc, sn_neg: 1'b1, cs_mag: bs, cs_neg: 1'b0};
    endcase
  end

  assign res_o = res_r;

endmodule

/* src/lrc_checker.sv */
module lrc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic [lrc_pkg::OUT_W-1:0] out_tdata,
  input logic                      out_tuser,
  input logic                      out_tvalid,
  input logic                      out_tready
);

  // Hold a stalled item
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output item changed while stalled");

  // Zero range always falls at or below the minimum
  a_zero_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[82:67] == 16'd0) |-> out_tuser)
    else $error("zero range not excluded");

  // Zero range maps to the origin
  a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[82:67] == 16'd0) |-> (out_tdata[50:0] == 51'd0))
    else $error("zero range gave nonzero position");

endmodule

bind lidar_return_to_cartesian_top lrc_checker u_chk (.*);

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import lrc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [15:0] distance;
    logic [3:0]  laser;
    logic [10:0] column;
    logic [11:0] column_count;
    logic [15:0] start_az;
    logic [15:0] end_az;
  } return_t;

  typedef struct packed {
    logic [16:0] pos_x;
    logic [16:0] pos_y;
    logic [16:0] pos_z;
    logic [15:0] azimuth;
    logic [15:0] range_val;
    logic        excluded;
    logic [10:0] column;
    logic [3:0]  laser;
  } point_t;

  typedef struct {
    return_t ret;
    bit      typed;
    point_t  pt;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic [IN_W-1:0]       in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_W-1:0]      out_tdata;
  logic                  out_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [1:0]            cfg_index;
  logic [16:0]           cfg_data;

  longint unsigned lim_min_range;
  longint          lim_z_upper;
  longint          lim_z_lower;

  point_t pending_points[$];
  int     mismatch_cnt;
  int     cycle_cnt;
  int     send_idle_pct;
  int     recv_idle_pct;

  lidar_return_to_cartesian_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sine and cosine of an angle in [0, 45] degrees, Q30
  function automatic void octant_sincos(input longint unsigned b,
                                        output longint unsigned s,
                                        output longint unsigned c);
    longint unsigned sdiv[6];
    longint unsigned cdiv[6];
    longint unsigned x, x2, t;
    sdiv = '{156, 110, 72, 42, 20, 6};
    cdiv = '{132, 90, 56, 30, 12, 2};
    x  = (b * 64'd3373259426 + 64'd9000) / 64'd18000;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    t  = 64'd1 << 30;
    for (int k = 0; k < 6; k++) t = (64'd1 << 30) - ((x2 * t) >> 30) / sdiv[k];
    s = (x * t) >> 30;
    t = 64'd1 << 30;
    for (int k = 0; k < 6; k++) t = (64'd1 << 30) - ((x2 * t) >> 30) / cdiv[k];
    c = t;
  endfunction

  // Full-turn sine and cosine by quadrant folding
  function automatic void turn_sincos(input longint unsigned a,
                                      output longint sn, output longint cs);
    longint unsigned q, r, s, c;
    q = (a / 9000) & 3;
    r = a % 9000;
    if (r > 4500) octant_sincos(9000 - r, c, s);
    else octant_sincos(r, s, c);
    case (q)
      0: begin sn = s;  cs = c;  end
      1: begin sn = c;  cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  function automatic longint scale_q8(input longint unsigned rc22, input longint t);
    longint unsigned m, mag;
    m   = (t < 0) ? -t : t;
    mag = (rc22 * m + (64'd1 << 43)) >> 44;
    return (t < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic point_t project_return(input return_t r);
    point_t p;
    longint unsigned rng, cnt, col, azu, rc22, m;
    longint az, den, sa, ca, se, ce, x, y, z;
    rng  = r.distance;
    cnt  = r.column_count;
    col  = r.column;
    if (cnt > 2048) cnt = 2048;
    if (cnt <= 1) begin
      az = r.start_az;
    end else begin
      den = cnt - 1;
      if (col > den) col = den;
      az = longint'(r.start_az) +
           ((longint'(r.end_az) - longint'(r.start_az)) * longint'(col)) / den;
    end
    azu = az;
    if (azu >= 36000) azu -= 36000;
    turn_sincos((longint'(r.laser) * 2 - 15) * 100 + 36000, se, ce);
    turn_sincos(azu, sa, ca);
    rc22 = (rng * ce + (64'd1 << 15)) >> 16;
    x = scale_q8(rc22, sa);
    y = scale_q8(rc22, ca);
    m = (se < 0) ? -se : se;
    z = (rng * m + (64'd1 << 29)) >> 30;
    if (se < 0) z = -z;
    p.pos_x     = x[16:0];
    p.pos_y     = y[16:0];
    p.pos_z     = z[16:0];
    p.azimuth   = azu[15:0];
    p.range_val = r.distance;
    p.excluded  = (rng <= lim_min_range) || !(z < lim_z_upper && z > lim_z_lower);
    p.column    = r.column;
    p.laser     = r.laser;
    return p;
  endfunction

  // Hand one item to the block, idling at random first
  task automatic send_return(input return_t r, input bit typed, input point_t typed_pt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, r.end_az, r.start_az, r.column_count, r.column, r.laser,
                  r.distance};
    do @(posedge clk); while (!in_tready);
    pending_points = {pending_points, (typed ? typed_pt : project_return(r))};
  endtask

  task automatic write_limit(input cfg_reg_e idx, input longint value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[16:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MIN_RANGE: lim_min_range = value & 64'hFFFF;
      REG_Z_UPPER:   lim_z_upper = $signed(value[16:0]);
      default:       lim_z_lower = $signed(value[16:0]);
    endcase
  endtask

  task automatic drain_points();
    in_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic return_t random_return();
    return_t r;
    r.distance = $urandom_range(65535);
    r.laser    = $urandom_range(15);
    r.column   = $urandom_range(2047);
    case ($urandom_range(9))
      0:       r.column_count = $urandom_range(1);
      1:       r.column_count = $urandom_range(4095, 2049);
      2:       r.column_count = 2048;
      3, 4:    r.column_count = $urandom_range(16, 2);
      default: r.column_count = $urandom_range(2048, 1);
    endcase
    // Keep most columns inside the frame
    if ($urandom_range(3) != 0 && r.column_count > 1)
      r.column = $urandom_range(r.column_count - 1);
    r.start_az = $urandom_range(35999);
    r.end_az   = $urandom_range(35999);
    return r;
  endfunction

  // Drive the result side and pace its stalls
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted point with the oldest pending one
  always @(posedge clk) begin
    point_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.pos_x     = out_tdata[16:0];
      got.pos_y     = out_tdata[33:17];
      got.pos_z     = out_tdata[50:34];
      got.azimuth   = out_tdata[66:51];
      got.range_val = out_tdata[82:67];
      got.column    = out_tdata[93:83];
      got.laser     = out_tdata[97:94];
      got.excluded  = out_tuser;
      if (pending_points.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected point %h", got);
      end else begin
        want = pending_points.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("point mismatch: exp x=%h y=%h z=%h az=%0d r=%0d ex=%b c=%0d l=%0d",
                     want.pos_x, want.pos_y, want.pos_z, want.azimuth, want.range_val,
                     want.excluded, want.column, want.laser,
                     "\n                act x=%h y=%h z=%h az=%0d r=%0d ex=%b c=%0d l=%0d",
                     got.pos_x, got.pos_y, got.pos_z, got.azimuth, got.range_val,
                     got.excluded, got.column, got.laser);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("lidar_return_to_cartesian_top: mismatch");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    point_t    zero_pt;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_MIN_RANGE;
    cfg_data      = '0;
    mismatch_cnt  = 0;
    cycle_cnt     = 0;
    send_idle_pct = 15;
    recv_idle_pct = 58;
    lim_min_range = 256;
    lim_z_upper   = 2560;
    lim_z_lower   = -512;
    zero_pt       = '0;

    // Directed returns: zero range, extremes, count and column corners
    row.typed = 1'b1;
    row.ret = '{16'd0, 4'd0, 11'd0, 12'd1, 16'd0, 16'd0};
    row.pt  = zero_pt;
    row.pt.excluded = 1'b1;
    rows = {rows, row};
    row.ret = '{16'd0, 4'd15, 11'd2047, 12'd0, 16'd12345, 16'd0};
    row.pt  = zero_pt;
    row.pt.azimuth = 16'd12345; row.pt.excluded = 1'b1;
    row.pt.column = 11'd2047; row.pt.laser = 4'd15;
    rows = {rows, row};
    row.typed = 1'b0;
    row.ret = '{16'd65535, 4'd0, 11'd0, 12'd2048, 16'd0, 16'd35999};       rows = {rows, row};
    row.ret = '{16'd65535, 4'd15, 11'd2047, 12'd2048, 16'd0, 16'd35999};   rows = {rows, row};
    row.ret = '{16'd65535, 4'd7, 11'd2047, 12'd4095, 16'd35999, 16'd0};    rows = {rows, row};
    row.ret = '{16'd256, 4'd8, 11'd5, 12'd3, 16'd100, 16'd200};            rows = {rows, row};
    row.ret = '{16'd257, 4'd8, 11'd1, 12'd2, 16'd9000, 16'd18000};         rows = {rows, row};
    row.ret = '{16'd5000, 4'd3, 11'd0, 12'd1, 16'd4500, 16'd0};            rows = {rows, row};
    row.ret = '{16'd5000, 4'd12, 11'd0, 12'd1, 16'd27000, 16'd0};          rows = {rows, row};
    row.ret = '{16'd5000, 4'd1, 11'd0, 12'd1, 16'd35999, 16'd0};           rows = {rows, row};
    row.ret = '{16'd40000, 4'd15, 11'd3, 12'd4, 16'd30000, 16'd39000};     rows = {rows, row};
    row.ret = '{16'd9000, 4'd14, 11'd1000, 12'd2001, 16'd35000, 16'd1000}; rows = {rows, row};
    row.ret = '{16'd2560, 4'd10, 11'd2, 12'd5, 16'd4501, 16'd13499};       rows = {rows, row};
    row.ret = '{16'd30000, 4'd0, 11'd100, 12'd50, 16'd18000, 16'd22500};   rows = {rows, row};
    row.ret = '{16'd1234, 4'd5, 11'd7, 12'd8, 16'd31500, 16'd35999};       rows = {rows, row};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_return(rows[i].ret, rows[i].typed, rows[i].pt);

    for (int phase = 0; phase < 4; phase++) begin
      if (phase > 0) begin
        drain_points();
        case (phase)
          1: begin
            send_idle_pct = 58; recv_idle_pct = 15;
            write_limit(REG_MIN_RANGE, 0);
            write_limit(REG_Z_UPPER, 65535);
            write_limit(REG_Z_LOWER, -65536);
          end
          2: begin
            send_idle_pct = 0; recv_idle_pct = 0;
            write_limit(REG_MIN_RANGE, 65535);
            write_limit(REG_Z_UPPER, -65536);
            write_limit(REG_Z_LOWER, 65535);
          end
          default: begin
            write_limit(REG_MIN_RANGE, $urandom_range(8000));
            write_limit(REG_Z_UPPER, $urandom_range(6000));
            write_limit(REG_Z_LOWER, -longint'($urandom_range(6000)));
          end
        endcase
      end
      for (int n = 0; n < 335; n++) begin
        // Hold off once until the pipeline has emptied
        if (phase == 0 && n == 100) begin
          in_tvalid <= 1'b0;
          while (pending_points.size() != 0) @(posedge clk);
        end
        send_return(random_return(), 1'b0, zero_pt);
      end
    end

    drain_points();
    if (mismatch_cnt == 0 && pending_points.size() == 0) begin
      $display("lidar_return_to_cartesian_top: match");
    end else begin
      $display("lidar_return_to_cartesian_top: mismatch");
    end
    $finish;
  end

endmodule
